>>> rtl/cmpq_pkg.sv
// Package for the CAN message priority queue: depth, field widths, codes and the
// message record that moves between the queue cells. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package cmpq_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;

  localparam int unsigned IdW    = 29;
  localparam int unsigned DataW  = 64;
  localparam int unsigned DlcW   = 4;
  localparam int unsigned PrioW  = 2;
  localparam int unsigned OccW   = 6;
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } command_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [DataW-1:0] data;
    logic [DlcW-1:0]  dlc;
    logic [PrioW-1:0] prio;
  } msg_t;

  // Shift controls broadcast to every cell of the chain.
  typedef struct packed {
    logic     enq;
    logic     deq;
    msg_t     new_msg;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/cmpq_cell.sv
// One slot of the sorted queue chain: holds a message and moves it toward the
// tail on an insert or toward the head on a removal. Depends on cmpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmpq_cell (
  input  wire                    clk_i,
  input  cmpq_pkg::cell_ctrl_t   ctrl_i,
  input  wire                    occupied_i,
  input  wire                    left_keep_i,
  input  cmpq_pkg::msg_t         left_msg_i,
  input  cmpq_pkg::msg_t         right_msg_i,
  output logic                   keep_o,
  output cmpq_pkg::msg_t         msg_o
);

  cmpq_pkg::msg_t msg_q, msg_d;

  // A stored entry stays put when it is at least as urgent as the new message.
  assign keep_o = occupied_i && (msg_q.prio <= ctrl_i.new_msg.prio);

  always_comb begin
    msg_d = msg_q;
    if (ctrl_i.deq) begin
      msg_d = right_msg_i;
    end else if (ctrl_i.enq && !keep_o) begin
      // The first slot that does not keep its entry takes the new message;
      // every slot behind it takes its left neighbor's entry.
      msg_d = left_keep_i ? ctrl_i.new_msg : left_msg_i;
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q <= msg_d;
  end

  assign msg_o = msg_q;

endmodule

`default_nettype wire

>>> rtl/can_message_priority_queue.sv
// Top level of the CAN message priority queue: a chain of cmpq_cell slots, the
// fill count and the result register. Depends on cmpq_pkg and cmpq_cell.
`timescale 1ns / 1ps
`default_nettype none

// The queue takes one request in every clock cycle: busy_o is always low, and
// the result of a request appears with done_o high in the next cycle, for one
// cycle only. Every slot compares its priority with the new message in parallel
// and the whole chain shifts in the same cycle, so the fill count and the slot
// contents are the only state that one request leaves for the next. Results
// cannot be held off and are never queued. Slot contents need no clearing after
// reset; the count alone tells which slots hold messages.
module can_message_priority_queue (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire                          command_i,
  input  wire [cmpq_pkg::IdW-1:0]      msg_id_i,
  input  wire [cmpq_pkg::DataW-1:0]    msg_data_i,
  input  wire [cmpq_pkg::DlcW-1:0]     msg_dlc_i,
  input  wire [cmpq_pkg::PrioW-1:0]    msg_priority_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [cmpq_pkg::IdW-1:0]     out_id_o,
  output logic [cmpq_pkg::DataW-1:0]   out_data_o,
  output logic [cmpq_pkg::DlcW-1:0]    out_dlc_o,
  output logic [cmpq_pkg::PrioW-1:0]   out_priority_o,
  output logic [cmpq_pkg::OccW-1:0]    occupancy_o
);

  localparam int unsigned Depth = cmpq_pkg::QUEUE_DEPTH;
  localparam int unsigned CntW  = cmpq_pkg::CntW;
  localparam int unsigned OccW  = cmpq_pkg::OccW;

  logic                 accept;
  logic                 is_deq;
  logic                 empty;
  logic                 full;
  cmpq_pkg::cell_ctrl_t ctrl;
  cmpq_pkg::msg_t       new_msg;
  cmpq_pkg::msg_t       cell_msg [Depth];
  logic [Depth-1:0]     cell_keep;

  logic [CntW-1:0]      count_q, count_d;
  logic                 done_q;
  cmpq_pkg::status_e    status_q, status_d;
  cmpq_pkg::msg_t       res_q, res_d;
  logic [OccW-1:0]      occ_q, occ_d;
  logic [CntW+OccW-1:0] count_ext;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign is_deq = (command_i == cmpq_pkg::CMD_DEQUEUE);
  assign empty  = (count_q == '0);
  assign full   = (count_q == CntW'(Depth));

  assign new_msg.id   = msg_id_i;
  assign new_msg.data = msg_data_i;
  assign new_msg.dlc  = msg_dlc_i;
  assign new_msg.prio = msg_priority_i;

  assign ctrl.enq     = accept && !is_deq && !full;
  assign ctrl.deq     = accept && is_deq && !empty;
  assign ctrl.new_msg = new_msg;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic           left_keep;
    cmpq_pkg::msg_t left_msg;
    cmpq_pkg::msg_t right_msg;

    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_msg  = new_msg;
    end else begin : g_mid
      assign left_keep = cell_keep[i-1];
      assign left_msg  = cell_msg[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign right_msg = new_msg;
    end else begin : g_body
      assign right_msg = cell_msg[i+1];
    end

    cmpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (count_q > CntW'(i)),
      .left_keep_i (left_keep),
      .left_msg_i  (left_msg),
      .right_msg_i (right_msg),
      .keep_o      (cell_keep[i]),
      .msg_o       (cell_msg[i])
    );
  end

  always_comb begin
    count_d  = count_q;
    status_d = cmpq_pkg::ST_OK;
    res_d    = '0;
    if (accept) begin
      if (is_deq) begin
        if (empty) begin
          status_d = cmpq_pkg::ST_EMPTY;
        end else begin
          res_d   = cell_msg[0];
          count_d = count_q - CntW'(1);
        end
      end else begin
        if (full) begin
          status_d = cmpq_pkg::ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
    end
  end

  // Occupancy is the updated count in six bits; the count never exceeds 32.
  assign count_ext = {{OccW{1'b0}}, count_d};
  assign occ_d     = count_ext[OccW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      res_q    <= res_d;
      occ_q    <= occ_d;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_id_o       = res_q.id;
  assign out_data_o     = res_q.data;
  assign out_dlc_o      = res_q.dlc;
  assign out_priority_o = res_q.prio;
  assign occupancy_o    = occ_q;

endmodule

`default_nettype wire

>>> rtl/cmpq_checker.sv
// Port-level checks for the CAN message priority queue, attached by bind.
// Depends on cmpq_pkg and on the ports of can_message_priority_queue.
`timescale 1ns / 1ps
`default_nettype none

module cmpq_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          start_i,
  input wire                          busy_o,
  input wire                          done_o,
  input wire [1:0]                    status_o,
  input wire [cmpq_pkg::IdW-1:0]      out_id_o,
  input wire [cmpq_pkg::DataW-1:0]    out_data_o,
  input wire [cmpq_pkg::DlcW-1:0]     out_dlc_o,
  input wire [cmpq_pkg::PrioW-1:0]    out_priority_o,
  input wire [cmpq_pkg::OccW-1:0]     occupancy_o
);

  localparam logic [cmpq_pkg::OccW-1:0] FullOcc = cmpq_pkg::OccW'(cmpq_pkg::QUEUE_DEPTH);

  // Every accepted request gives exactly one result in the following cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted request produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result strobe without a request");

  // A refused request carries no message.
  a_zero_message: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != cmpq_pkg::ST_OK) |->
      (out_id_o == '0 && out_data_o == '0 && out_dlc_o == '0 && out_priority_o == '0))
    else $error("refused request returned message fields");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == cmpq_pkg::ST_EMPTY) |-> (occupancy_o == '0))
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == cmpq_pkg::ST_FULL) |-> (occupancy_o == FullOcc))
    else $error("full status without a full queue");

endmodule

bind can_message_priority_queue cmpq_checker u_cmpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .status_o       (status_o),
  .out_id_o       (out_id_o),
  .out_data_o     (out_data_o),
  .out_dlc_o      (out_dlc_o),
  .out_priority_o (out_priority_o),
  .occupancy_o    (occupancy_o)
);

`default_nettype wire
